>>> sv/bvmf_pkg.sv
// Shared constants, types and control structs of the battery voltage mode filter.
package bvmf_pkg;

	localparam int HISTORY_DEPTH  = 25;
	localparam int DISTINCT_SLOTS = 10;

	localparam int ADC_W   = 13;
	localparam int CODE_W  = 10;
	localparam int FS_W    = 19;
	localparam int STEP_W  = 4;
	localparam int VOLT_W  = 11;
	localparam int HELD_W  = 5;
	localparam int PROD_W  = CODE_W + FS_W;
	localparam int QUOT_W  = 12;
	localparam int DVS_W   = 10;
	localparam int SUM_W   = QUOT_W + 1;

	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SLOT_CW = $clog2(DISTINCT_SLOTS + 1);
	localparam int SLOT_IW = (DISTINCT_SLOTS > 1) ? $clog2(DISTINCT_SLOTS) : 1;
	localparam int STEPS_W = $clog2(QUOT_W + 1);

	localparam int CFG_AW  = 1;
	localparam int CFG_DW  = FS_W;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	localparam logic [CFG_AW-1:0] REG_FULL_SCALE = 1'b0;
	localparam logic [CFG_AW-1:0] REG_QUANT_STEP = 1'b1;

	localparam logic [FS_W-1:0]   FULL_SCALE_RST = 19'd25600;
	localparam logic [STEP_W-1:0] QUANT_STEP_RST = 4'd3;
	localparam logic [DVS_W-1:0]  ADC_FULL_CODE  = 10'd1023;
	localparam logic [VOLT_W-1:0] VOLT_MAX       = 11'd2047;

	typedef struct packed {
		logic               start;
		logic [DVS_W-1:0]   rem_init;
		logic [QUOT_W-1:0]  dvd;
		logic [DVS_W-1:0]   dvs;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [QUOT_W-1:0]  quot;
		logic [DVS_W-1:0]   rem;
	} div_res_t;

	typedef struct packed {
		logic               done;
		logic [VOLT_W-1:0]  voted;
		logic [CNT_W-1:0]   held;
	} vote_res_t;

endpackage

>>> sv/bvmf_div.sv
// Restoring divider: one quotient bit per cycle, one step per quotient bit.
module bvmf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bvmf_pkg::div_req_t  req,
	output bvmf_pkg::div_res_t  res
);

	logic                          busy_q;
	logic [bvmf_pkg::STEPS_W-1:0]  cnt_q;
	logic [bvmf_pkg::DVS_W-1:0]    rem_q;
	logic [bvmf_pkg::QUOT_W-1:0]   sh_q;
	logic [bvmf_pkg::DVS_W-1:0]    dvs_q;
	logic [bvmf_pkg::DVS_W:0]      trial;
	logic                          fits;

	assign trial = {rem_q, sh_q[bvmf_pkg::QUOT_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= bvmf_pkg::STEPS_W'(bvmf_pkg::QUOT_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			sh_q  <= req.dvd;
			dvs_q <= req.dvs;
		end else if (busy_q && cnt_q != '0) begin
			// shift in next dividend bit, subtract when it fits
			rem_q <= fits ? bvmf_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : trial[bvmf_pkg::DVS_W-1:0];
			sh_q  <= {sh_q[bvmf_pkg::QUOT_W-2:0], fits};
		end
	end

	assign res.done = busy_q && cnt_q == '0;
	assign res.quot = sh_q;
	assign res.rem  = rem_q;

endmodule

>>> sv/bvmf_vote.sv
// Reading history and serial majority vote over distinct values.
module bvmf_vote (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [bvmf_pkg::VOLT_W-1:0]   push_val,
	output bvmf_pkg::vote_res_t           res
);

	typedef enum logic [2:0] {
		V_IDLE = 3'b001,
		V_WALK = 3'b010,
		V_PICK = 3'b100
	} vstate_t;

	vstate_t                        state_q;
	logic [bvmf_pkg::VOLT_W-1:0]    hist_q [bvmf_pkg::HISTORY_DEPTH];
	logic [bvmf_pkg::CNT_W-1:0]     cnt_q;
	logic [bvmf_pkg::CNT_W-1:0]     idx_q;
	logic [bvmf_pkg::VOLT_W-1:0]    slot_val_q [bvmf_pkg::DISTINCT_SLOTS];
	logic [bvmf_pkg::CNT_W-1:0]     slot_cnt_q [bvmf_pkg::DISTINCT_SLOTS];
	logic [bvmf_pkg::SLOT_CW-1:0]   used_q;
	logic [bvmf_pkg::SLOT_CW-1:0]   k_q;
	logic [bvmf_pkg::CNT_W-1:0]     best_cnt_q;
	logic [bvmf_pkg::VOLT_W-1:0]    best_val_q;
	logic                           done_q;
	logic [bvmf_pkg::VOLT_W-1:0]    cur_val;
	logic [bvmf_pkg::DISTINCT_SLOTS-1:0] hit;

	assign cur_val = hist_q[idx_q[bvmf_pkg::IDX_W-1:0]];

	always_comb begin
		for (int k = 0; k < bvmf_pkg::DISTINCT_SLOTS; k++) begin
			hit[k] = (bvmf_pkg::SLOT_CW'(k) < used_q) && (slot_val_q[k] == cur_val);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hist_q[0] <= push_val;
			for (int i = 1; i < bvmf_pkg::HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == V_WALK && idx_q != cnt_q && cur_val != '0) begin
			for (int k = 0; k < bvmf_pkg::DISTINCT_SLOTS; k++) begin
				if (hit[k]) begin
					slot_cnt_q[k] <= slot_cnt_q[k] + 1'b1;
				end
			end
			// open a new slot for an unseen value while slots remain
			if (hit == '0 && used_q < bvmf_pkg::SLOT_CW'(bvmf_pkg::DISTINCT_SLOTS)) begin
				slot_val_q[used_q[bvmf_pkg::SLOT_IW-1:0]] <= cur_val;
				slot_cnt_q[used_q[bvmf_pkg::SLOT_IW-1:0]] <= bvmf_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= V_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			used_q     <= '0;
			k_q        <= '0;
			best_cnt_q <= '0;
			best_val_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= state_q == V_PICK && k_q == used_q;
			unique case (state_q)
				V_IDLE: begin
					if (push) begin
						if (cnt_q < bvmf_pkg::CNT_W'(bvmf_pkg::HISTORY_DEPTH)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						idx_q   <= '0;
						used_q  <= '0;
						state_q <= V_WALK;
					end
				end
				V_WALK: begin
					if (idx_q == cnt_q) begin
						k_q        <= '0;
						best_cnt_q <= '0;
						best_val_q <= '0;
						state_q    <= V_PICK;
					end else begin
						if (cur_val != '0 && hit == '0 &&
						    used_q < bvmf_pkg::SLOT_CW'(bvmf_pkg::DISTINCT_SLOTS)) begin
							used_q <= used_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				V_PICK: begin
					if (k_q == used_q) begin
						state_q <= V_IDLE;
					end else begin
						// strict compare keeps the earliest slot on a tie
						if (slot_cnt_q[k_q[bvmf_pkg::SLOT_IW-1:0]] > best_cnt_q) begin
							best_cnt_q <= slot_cnt_q[k_q[bvmf_pkg::SLOT_IW-1:0]];
							best_val_q <= slot_val_q[k_q[bvmf_pkg::SLOT_IW-1:0]];
						end
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= V_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.voted = best_val_q;
	assign res.held  = cnt_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= bvmf_pkg::SLOT_CW'(bvmf_pkg::DISTINCT_SLOTS))
		else $error("slot count beyond slot capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == V_WALK |-> idx_q <= cnt_q)
		else $error("history walk past valid entries");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("vote done held for more than one cycle");

endmodule

>>> sv/battery_voltage_mode_filter.sv
// Top level: scaling, step rounding and sequencing of the battery voltage mode filter.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one item: the sum of eight 10-bit ADC
//   conversions. m_tvalid/m_tready/m_tdata return one result item per input.
//   cfg_wen/cfg_addr/cfg_wdata write full_scale_q8 (index 0) and quant_step
//   (index 1); write only while no item is in flight.
// Sequence:
//   An item passes from acceptance to m_tvalid through the multiply state, the
//   scale state (divide by 1023 with a fold and two compares), the serial divider
//   for the remainder by quant_step (skipped for a zero step), the rounding state,
//   a history walk over the valid entries, a slot pass over the distinct values,
//   and the handoff. s_tready is high only while the sequencer is idle, so the
//   next item is taken in the same cycle that m_tvalid rises at the earliest.
// Reset: arst_n clears the history fill count, the sequencer and the output
//   valid, and loads full_scale_q8 = 25600 and quant_step = 3.
// Stall: a finished result waits in the output register; a new item may be
//   accepted meanwhile and its result holds back until the waiting one is taken.
module battery_voltage_mode_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [bvmf_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [bvmf_pkg::CFG_DW-1:0]        cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bvmf_pkg::S_TDATA_W-1:0]     s_tdata,   // [12:0] adc_accum
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [10:0] voted_centivolts, [21:11] quantized_centivolts,
	// [26:22] readings_held, [27] clipped
	output logic [bvmf_pkg::M_TDATA_W-1:0]     m_tdata
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b000_0001,
		ST_MUL    = 7'b000_0010,
		ST_SCALE  = 7'b000_0100,
		ST_RWAIT  = 7'b000_1000,
		ST_ROUND  = 7'b001_0000,
		ST_VWAIT  = 7'b010_0000,
		ST_FIN    = 7'b100_0000
	} state_t;

	state_t                            state_q;
	logic [bvmf_pkg::FS_W-1:0]         fs_q;
	logic [bvmf_pkg::STEP_W-1:0]       step_q;
	logic [bvmf_pkg::CODE_W-1:0]       code_q;
	logic [bvmf_pkg::PROD_W-1:0]       prod_q;
	logic [bvmf_pkg::QUOT_W-1:0]       v_q;
	logic [bvmf_pkg::STEP_W-1:0]       r_q;
	logic [bvmf_pkg::VOLT_W-1:0]       qv_q;
	logic                              clip_q;
	logic                              out_valid_q;
	logic [bvmf_pkg::M_TDATA_W-1:0]    out_data_q;

	bvmf_pkg::div_req_t                div_req;
	bvmf_pkg::div_res_t                div_res;
	bvmf_pkg::vote_res_t               vote_res;
	logic                              push;

	logic [bvmf_pkg::QUOT_W-1:0]       fold;
	logic [bvmf_pkg::QUOT_W-1:0]       scaled;
	logic [bvmf_pkg::SUM_W-1:0]        rounded;
	logic                              round_up;
	logic                              clip;
	logic                              out_free;

	assign s_tready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= bvmf_pkg::FULL_SCALE_RST;
			step_q <= bvmf_pkg::QUANT_STEP_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				bvmf_pkg::REG_FULL_SCALE: fs_q   <= cfg_wdata;
				bvmf_pkg::REG_QUANT_STEP: step_q <= cfg_wdata[bvmf_pkg::STEP_W-1:0];
			endcase
		end
	end

	// x = 1024*hi + lo = 1023*hi + (hi + lo), and hi + lo stays below 3*1023
	assign fold   = bvmf_pkg::QUOT_W'(prod_q[bvmf_pkg::PROD_W-1:18])
	              + bvmf_pkg::QUOT_W'(prod_q[17:8]);
	assign scaled = bvmf_pkg::QUOT_W'(prod_q[bvmf_pkg::PROD_W-1:18])
	              + ((fold >= bvmf_pkg::QUOT_W'({bvmf_pkg::ADC_FULL_CODE, 1'b0}))
	                 ? bvmf_pkg::QUOT_W'(2)
	                 : (fold >= bvmf_pkg::QUOT_W'(bvmf_pkg::ADC_FULL_CODE))
	                   ? bvmf_pkg::QUOT_W'(1) : bvmf_pkg::QUOT_W'(0));

	// divider request: remainder of the scaled reading by the step
	always_comb begin
		div_req = '0;
		if (state_q == ST_SCALE && step_q != '0) begin
			div_req.start    = 1'b1;
			div_req.dvd      = scaled;
			div_req.dvs      = bvmf_pkg::DVS_W'(step_q);
		end
	end

	assign round_up = r_q > (step_q >> 1);
	assign rounded  = {1'b0, v_q} - bvmf_pkg::SUM_W'(r_q)
	                + (round_up ? bvmf_pkg::SUM_W'(step_q) : '0);
	assign clip     = rounded > bvmf_pkg::SUM_W'(bvmf_pkg::VOLT_MAX);
	assign push     = state_q == ST_ROUND;

	bvmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	bvmf_vote u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_val (bvmf_pkg::VOLT_W'(clip ? bvmf_pkg::VOLT_MAX
		                                  : rounded[bvmf_pkg::VOLT_W-1:0])),
		.res      (vote_res)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:  code_q <= s_tdata[bvmf_pkg::ADC_W-1:3];
			ST_MUL:   prod_q <= code_q * fs_q;
			ST_SCALE: begin
				v_q <= scaled;
				r_q <= '0;
			end
			ST_RWAIT: begin
				if (div_res.done) begin
					r_q <= div_res.rem[bvmf_pkg::STEP_W-1:0];
				end
			end
			ST_ROUND: begin
				qv_q   <= clip ? bvmf_pkg::VOLT_MAX : rounded[bvmf_pkg::VOLT_W-1:0];
				clip_q <= clip;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (s_tvalid) state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_SCALE;
				ST_SCALE:  state_q <= (step_q != '0) ? ST_RWAIT : ST_ROUND;
				ST_RWAIT:  if (div_res.done) state_q <= ST_ROUND;
				ST_ROUND:  state_q <= ST_VWAIT;
				ST_VWAIT:  if (vote_res.done) state_q <= ST_FIN;
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= bvmf_pkg::M_TDATA_W'({clip_q,
			                                    bvmf_pkg::HELD_W'(vote_res.held),
			                                    qv_q,
			                                    vote_res.voted});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in flight");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VWAIT && clip_q |-> qv_q == bvmf_pkg::VOLT_MAX)
		else $error("clipped reading not saturated");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vote_res.held <= bvmf_pkg::CNT_W'(bvmf_pkg::HISTORY_DEPTH))
		else $error("history count beyond depth");

endmodule

>>> verif/bvmf_checker.sv
`timescale 1ns / 1ps
// Result checker for the battery voltage mode filter: mirrors the filter and compares every item.
module bvmf_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [bvmf_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [bvmf_pkg::CFG_DW-1:0]        cfg_wdata,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [bvmf_pkg::S_TDATA_W-1:0]     s_tdata,   // [12:0] adc_accum
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// [10:0] voted_centivolts, [21:11] quantized_centivolts,
	// [26:22] readings_held, [27] clipped
	input  logic [bvmf_pkg::M_TDATA_W-1:0]     m_tdata,
	output int                                 items_taken,
	output int                                 results_checked,
	output int                                 pending,
	output int                                 fail_count
);

	typedef struct packed {
		logic [bvmf_pkg::VOLT_W-1:0] voted;
		logic [bvmf_pkg::VOLT_W-1:0] quantized;
		logic [bvmf_pkg::HELD_W-1:0] held;
		logic                        clipped;
	} reading_t;

	logic [bvmf_pkg::FS_W-1:0]   scale_q8;
	logic [bvmf_pkg::STEP_W-1:0] step_cv;
	logic [bvmf_pkg::VOLT_W-1:0] history [bvmf_pkg::HISTORY_DEPTH];
	int                          history_fill;
	reading_t                    expected_readings [$];

	// Scale, round and saturate one reading, push it and vote over the history.
	function automatic reading_t predict_reading(input logic [bvmf_pkg::ADC_W-1:0] accum);
		reading_t                    res;
		logic [63:0]                 code;
		logic [63:0]                 volts;
		logic [63:0]                 rem;
		logic [bvmf_pkg::VOLT_W-1:0] slot_val [bvmf_pkg::DISTINCT_SLOTS];
		int                          slot_cnt [bvmf_pkg::DISTINCT_SLOTS];
		int                          used;
		int                          best_cnt;
		bit                          hit;
		code = 64'(accum >> 3);
		volts = (code * 64'(scale_q8)) / (64'(bvmf_pkg::ADC_FULL_CODE) * 64'd256);
		res.clipped = 1'b0;
		if (step_cv != 0) begin
			rem = volts % 64'(step_cv);
			volts = volts - rem;
			if (rem > 64'(step_cv / 2))
				volts = volts + 64'(step_cv);
		end
		if (volts > 64'(bvmf_pkg::VOLT_MAX)) begin
			volts = 64'(bvmf_pkg::VOLT_MAX);
			res.clipped = 1'b1;
		end
		for (int i = bvmf_pkg::HISTORY_DEPTH - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = volts[bvmf_pkg::VOLT_W-1:0];
		if (history_fill < bvmf_pkg::HISTORY_DEPTH)
			history_fill++;
		res.quantized = volts[bvmf_pkg::VOLT_W-1:0];
		res.held = bvmf_pkg::HELD_W'(history_fill);

		// newest first; zeros sit out, late newcomers are dropped once slots run out
		used = 0;
		for (int i = 0; i < history_fill; i++) begin
			hit = 1'b0;
			if (history[i] != '0) begin
				for (int k = 0; k < used; k++) begin
					if (!hit && slot_val[k] == history[i]) begin
						slot_cnt[k]++;
						hit = 1'b1;
					end
				end
				if (!hit && used < bvmf_pkg::DISTINCT_SLOTS) begin
					slot_val[used] = history[i];
					slot_cnt[used] = 1;
					used++;
				end
			end
		end
		res.voted = '0;
		best_cnt = 0;
		for (int k = 0; k < used; k++) begin
			if (slot_cnt[k] > best_cnt) begin
				best_cnt = slot_cnt[k];
				res.voted = slot_val[k];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			scale_q8 = bvmf_pkg::FULL_SCALE_RST;
			step_cv = bvmf_pkg::QUANT_STEP_RST;
			for (int i = 0; i < bvmf_pkg::HISTORY_DEPTH; i++)
				history[i] = '0;
			history_fill = 0;
			expected_readings.delete();
			items_taken = 0;
			results_checked = 0;
			fail_count = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_addr)
					bvmf_pkg::REG_FULL_SCALE: scale_q8 = cfg_wdata[bvmf_pkg::FS_W-1:0];
					bvmf_pkg::REG_QUANT_STEP: step_cv = cfg_wdata[bvmf_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			// take the result before the new item so an empty queue is caught
			if (m_tvalid && m_tready) begin
				got.voted = m_tdata[10:0];
				got.quantized = m_tdata[21:11];
				got.held = m_tdata[26:22];
				got.clipped = m_tdata[27];
				results_checked++;
				if (expected_readings.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: voted %0d quantized %0d held %0d clipped %0d",
							got.voted, got.quantized, got.held, got.clipped);
				end else begin
					want = expected_readings.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d mismatch: expected voted %0d quantized %0d held %0d clipped %0d",
								results_checked, want.voted, want.quantized, want.held,
								want.clipped);
							$display("  got voted %0d quantized %0d held %0d clipped %0d",
								got.voted, got.quantized, got.held, got.clipped);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(predict_reading(s_tdata[bvmf_pkg::ADC_W-1:0]));
				items_taken++;
			end
		end
		pending = expected_readings.size();
	end

endmodule

>>> verif/battery_voltage_mode_filter_test.sv
`timescale 1ns / 1ps
// Testbench top of the battery voltage mode filter: stimulus, register settings and verdict.
module battery_voltage_mode_filter_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 70;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wen;
	logic [bvmf_pkg::CFG_AW-1:0]     cfg_addr;
	logic [bvmf_pkg::CFG_DW-1:0]     cfg_wdata;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [bvmf_pkg::S_TDATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [bvmf_pkg::M_TDATA_W-1:0]  m_tdata;

	int items_taken;
	int results_checked;
	int pending;
	int fail_count;
	int cycle_count;
	int settings_used;
	int stall_left;
	bit steady;

	// zero, above range, small codes, ties, then more distinct values than slots
	logic [bvmf_pkg::ADC_W-1:0] first_readings [20] = '{
		13'd0, 13'd8191, 13'd7, 13'd8, 13'd4000, 13'd4000, 13'd2000, 13'd2000,
		13'd400, 13'd800, 13'd1200, 13'd1600, 13'd2400, 13'd2800, 13'd3200,
		13'd3600, 13'd4400, 13'd4800, 13'd5200, 13'd5600
	};

	battery_voltage_mode_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	bvmf_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.items_taken     (items_taken),
		.results_checked (results_checked),
		.pending         (pending),
		.fail_count      (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("battery_voltage_mode_filter verification failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (steady) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Offer one item and hold it until the checker has seen it taken.
	task automatic send_reading(input logic [bvmf_pkg::ADC_W-1:0] accum);
		int gap;
		int seen;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(bvmf_pkg::S_TDATA_W-bvmf_pkg::ADC_W){1'b0}}, accum};
		seen = items_taken;
		@(negedge clk);
		while (items_taken == seen)
			@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [bvmf_pkg::CFG_AW-1:0] addr,
		input logic [bvmf_pkg::CFG_DW-1:0] data);
		cfg_wen <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [bvmf_pkg::FS_W-1:0] scale,
		input logic [bvmf_pkg::STEP_W-1:0] step);
		drain_results();
		write_reg(bvmf_pkg::REG_FULL_SCALE, scale);
		write_reg(bvmf_pkg::REG_QUANT_STEP, bvmf_pkg::CFG_DW'(step));
		settings_used++;
	endtask

	initial begin
		logic [bvmf_pkg::ADC_W-1:0] accum;
		logic [bvmf_pkg::ADC_W-1:0] pool [14];
		int pool_n;
		int r;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		steady = 1'b0;
		stall_left = 0;
		cycle_count = 0;
		settings_used = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (first_readings[i])
			send_reading(first_readings[i]);

		// full scale at maximum: rounding up past the top saturates
		apply_setting(19'h7FFFF, 4'd8);
		send_reading(13'd8191);
		send_reading(13'd8184);
		// no rounding
		apply_setting(19'h7FFFF, 4'd0);
		send_reading(13'd8191);
		send_reading(13'd4444);
		// every reading scales to zero
		apply_setting(19'd0, 4'd15);
		send_reading(13'd8191);
		apply_setting(19'd1, 4'd1);
		send_reading(13'd8191);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: apply_setting(19'h7FFFF, bvmf_pkg::STEP_W'($urandom_range(0, 15)));
				1: apply_setting(bvmf_pkg::FS_W'($urandom_range(1, 4000)),
					bvmf_pkg::STEP_W'($urandom_range(0, 15)));
				default: apply_setting(bvmf_pkg::FS_W'($urandom_range(4000, 524287)),
					bvmf_pkg::STEP_W'($urandom_range(0, 15)));
			endcase
			// a small pool of codes makes values repeat so the vote has work to do
			pool_n = $urandom_range(2, 14);
			for (int i = 0; i < pool_n; i++)
				pool[i] = bvmf_pkg::ADC_W'($urandom_range(0, 1023) * 8);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					accum = pool[$urandom_range(0, pool_n - 1)]
						+ bvmf_pkg::ADC_W'($urandom_range(0, 7));
				else if (r < 88)
					accum = bvmf_pkg::ADC_W'($urandom_range(0, 8191));
				else
					accum = bvmf_pkg::ADC_W'($urandom_range(0, 15));
				send_reading(accum);
			end
		end

		drain_results();
		repeat (80) @(negedge clk);
		$display("%0d readings sent under %0d register settings, %0d results compared",
			items_taken, settings_used, results_checked);
		$display("covered zero and saturated readings, zero step, ties and overfull vote slots");
		if (fail_count == 0 && pending == 0)
			$display("battery_voltage_mode_filter verification clean");
		else
			$display("battery_voltage_mode_filter verification failed");
		$finish;
	end

endmodule
